// ===== rtl/smpq_pkg.sv =====
// Package for the sorted minimum priority queue: sizes, codes and the
// per-cycle control word broadcast to the cell chain. No dependencies.
package smpq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int DATA_W      = 32;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_REMOVE = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    STAT_DONE       = 2'd0,
    STAT_EMPTY_POP  = 2'd1,
    STAT_FULL_DROP  = 2'd2
  } status_t;

  typedef struct packed {
    logic                     insert_en;
    logic                     remove_en;
    logic signed [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage

// ===== rtl/smpq_cell.sv =====
// One storage cell of the sorted chain: holds one entry, compares it with
// the broadcast word and shifts with its neighbors. Uses smpq_pkg.
module smpq_cell (
  input  logic                              clk,
  input  smpq_pkg::cell_ctrl_t              ctrl,
  input  logic                              valid,
  input  logic signed [smpq_pkg::DATA_W-1:0] left_entry,
  input  logic                              left_gt,
  input  logic signed [smpq_pkg::DATA_W-1:0] right_entry,
  output logic signed [smpq_pkg::DATA_W-1:0] entry,
  output logic                              gt
);

  logic signed [smpq_pkg::DATA_W-1:0] entry_next;

  // entry strictly greater than the new word: it moves one place right
  assign gt = valid && (entry > ctrl.value);

  always_comb begin
    entry_next = entry;
    if (ctrl.insert_en) begin
      if (left_gt) begin
        entry_next = left_entry;
      end else if (gt || !valid) begin
        entry_next = ctrl.value;
      end
    end else if (ctrl.remove_en) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// ===== rtl/sorted_min_priority_queue_core.sv =====
// Top level of the sorted minimum priority queue: a chain of smpq_cell
// entries with a shared count and registered result. Uses smpq_pkg.
//
//  channel   handshake          words
//  command   start / busy       action, item_value
//  result    done (1 cycle)     removed_value, status, item_count, is_empty
//
// One command per cycle: busy is always low. The result of a command
// accepted at one edge is shown for the following cycle under done.
// All cells update in that same edge; each cell looks only at its neighbors and the broadcast word.
// Reset clears the count and done; entries are not cleared.
// The receiver cannot stall; done is never held.
module sorted_min_priority_queue_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic                               action,
  input  logic signed [smpq_pkg::DATA_W-1:0] item_value,
  output logic                               done,
  output logic signed [smpq_pkg::DATA_W-1:0] removed_value,
  output logic [1:0]                         status,
  output logic [4:0]                         item_count,
  output logic                               is_empty
);

  localparam int D = smpq_pkg::QUEUE_DEPTH;
  localparam int W = smpq_pkg::DATA_W;
  localparam int C = smpq_pkg::CNT_W;

  logic [C-1:0]         count;
  logic [C-1:0]         count_next;
  logic                 accept;
  logic                 full;
  logic                 empty;
  smpq_pkg::cell_ctrl_t ctrl;
  smpq_pkg::status_t    status_next;
  logic signed [W-1:0]  removed_next;
  logic signed [W-1:0]  entries [D];
  logic                 gts     [D];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count == C'(D));
  assign empty  = (count == '0);

  always_comb begin
    ctrl.insert_en = 1'b0;
    ctrl.remove_en = 1'b0;
    ctrl.value     = item_value;
    count_next     = count;
    status_next    = smpq_pkg::STAT_DONE;
    removed_next   = '0;
    if (accept) begin
      unique case (smpq_pkg::action_t'(action))
        smpq_pkg::ACT_INSERT: begin
          if (full) begin
            status_next = smpq_pkg::STAT_FULL_DROP;
          end else begin
            ctrl.insert_en = 1'b1;
            count_next     = count + C'(1);
          end
        end
        smpq_pkg::ACT_REMOVE: begin
          if (empty) begin
            status_next = smpq_pkg::STAT_EMPTY_POP;
          end else begin
            ctrl.remove_en = 1'b1;
            removed_next   = entries[0];
            count_next     = count - C'(1);
          end
        end
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < D; i++) begin : g_cell
    logic signed [W-1:0] left_entry;
    logic signed [W-1:0] right_entry;
    logic                left_gt;
    if (i == 0) begin : g_first
      assign left_entry = item_value;
      assign left_gt    = 1'b0;
    end else begin : g_mid
      assign left_entry = entries[i-1];
      assign left_gt    = gts[i-1];
    end
    if (i == D - 1) begin : g_last
      assign right_entry = entries[i];
    end else begin : g_inner
      assign right_entry = entries[i+1];
    end
    smpq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .valid       (C'(i) < count),
      .left_entry  (left_entry),
      .left_gt     (left_gt),
      .right_entry (right_entry),
      .entry       (entries[i]),
      .gt          (gts[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      removed_value <= removed_next;
      status        <= status_next;
    end
  end

  assign item_count = 5'(count);
  assign is_empty   = empty;

endmodule

// ===== tb/sorted_min_priority_queue_core_tb.sv =====
// Testbench for sorted_min_priority_queue_core: drives insert/remove words and checks every
// result against an in-bench sorted-list predictor held in a small scoreboard class.
// Depends on smpq_pkg and the core RTL; needs no files or arguments.
module sorted_min_priority_queue_core_tb;
  import smpq_pkg::*;

  localparam int RAND_WORDS = 1130;
  localparam int BURST_LEN  = 40;

  typedef struct {
    logic signed [DATA_W-1:0] removed_value;
    status_t                  status;
    logic [4:0]               item_count;
    logic                     is_empty;
  } queue_result_t;

  class queue_scoreboard;
    logic signed [DATA_W-1:0] entries [QUEUE_DEPTH];
    int                       held;
    queue_result_t            pending [$];
    int                       errors;

    function new();
      held   = 0;
      errors = 0;
    endfunction

    // Equal values go behind existing ones so ties leave in arrival order.
    function void note_command(action_t act, logic signed [DATA_W-1:0] val);
      queue_result_t r;
      int            pos;
      r.removed_value = '0;
      r.status        = STAT_DONE;
      if (act == ACT_INSERT) begin
        if (held >= QUEUE_DEPTH) begin
          r.status = STAT_FULL_DROP;
        end else begin
          pos = 0;
          while (pos < held && !(entries[pos] > val)) pos++;
          for (int k = held; k > pos; k--) entries[k] = entries[k-1];
          entries[pos] = val;
          held++;
        end
      end else begin
        if (held == 0) begin
          r.status = STAT_EMPTY_POP;
        end else begin
          r.removed_value = entries[0];
          for (int k = 1; k < held; k++) entries[k-1] = entries[k];
          held--;
        end
      end
      r.item_count = 5'(held);
      r.is_empty   = (held == 0);
      pending.push_back(r);
    endfunction

    function void flag_field(string field, logic [DATA_W-1:0] exp, logic [DATA_W-1:0] got);
      if (got !== exp) begin
        errors++;
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, exp, got);
      end
    endfunction

    function void check_result(logic signed [DATA_W-1:0] rv, logic [1:0] st,
                               logic [4:0] cnt, logic emp);
      queue_result_t e;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word: expected none, actual value %0h status %0d",
                 $time, rv, st);
        return;
      end
      e = pending.pop_front();
      flag_field("removed_value", e.removed_value, rv);
      flag_field("status", 32'(e.status), 32'(st));
      flag_field("item_count", 32'(e.item_count), 32'(cnt));
      flag_field("is_empty", 32'(e.is_empty), 32'(emp));
    endfunction
  endclass

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic                     action;
  logic signed [DATA_W-1:0] item_value;
  logic                     done;
  logic signed [DATA_W-1:0] removed_value;
  logic [1:0]               status;
  logic [4:0]               item_count;
  logic                     is_empty;

  queue_scoreboard sb;
  int              idle_pct;

  sorted_min_priority_queue_core uut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .action        (action),
    .item_value    (item_value),
    .done          (done),
    .removed_value (removed_value),
    .status        (status),
    .item_count    (item_count),
    .is_empty      (is_empty)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(removed_value, status, item_count, is_empty);
      if (start && !busy) sb.note_command(action_t'(action), item_value);
    end
  end

  task automatic drive_word(action_t act, logic signed [DATA_W-1:0] val);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start      <= 1'b0;
      action     <= 1'($urandom);
      item_value <= $urandom;
      @(negedge clk);
    end
    start      <= 1'b1;
    action     <= act;
    item_value <= val;
    do @(posedge clk); while (busy);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return $signed($urandom_range(8)) - 4;
      7: begin
        case ($urandom_range(3))
          0:       return 32'sh7FFF_FFFF;
          1:       return 32'sh8000_0000;
          2:       return '0;
          default: return -1;
        endcase
      end
      8:       return 32'sh8000_0000 + $urandom_range(3);
      default: return 32'sh7FFF_FFFF - $urandom_range(3);
    endcase
  endfunction

  initial begin
    logic signed [DATA_W-1:0] fill_vals [QUEUE_DEPTH];
    int                       phase_pct [3];
    int                       insert_bias;
    action_t                  act;

    fill_vals = '{32'sh7FFF_FFFF, 32'sh8000_0000, 0, -1, 1, 5, 5, 5,
                  -5, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh5555_5555,
                  32'shAAAA_AAAA, 0, -1, 3};
    phase_pct = '{6, 59, 0};
    sb         = new();
    idle_pct   = phase_pct[0];
    rst        = 1'b1;
    start      = 1'b0;
    action     = 1'b0;
    item_value = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty pop, fill to the brim, drop on full, then a few pops
    drive_word(ACT_REMOVE, '0);
    foreach (fill_vals[i]) drive_word(ACT_INSERT, fill_vals[i]);
    drive_word(ACT_INSERT, 32'sh8000_0000);
    drive_word(ACT_INSERT, 32'sh7FFF_FFFF);
    repeat (4) drive_word(ACT_REMOVE, 32'shFFFF_FFFF);

    insert_bias = 50;
    foreach (phase_pct[p]) begin
      idle_pct = phase_pct[p];
      for (int n = 0; n < RAND_WORDS / 3; n++) begin
        if (n % BURST_LEN == 0) begin
          case ($urandom_range(2))
            0:       insert_bias = 15;
            1:       insert_bias = 50;
            default: insert_bias = 85;
          endcase
        end
        act = ($urandom_range(99) < insert_bias) ? ACT_INSERT : ACT_REMOVE;
        drive_word(act, pick_value());
      end
    end

    @(negedge clk);
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/smpq_pkg.sv
rtl/smpq_cell.sv
rtl/sorted_min_priority_queue_core.sv
tb/sorted_min_priority_queue_core_tb.sv
